// ----- sv/brr_pkg.sv -----
// shared types and constants for the block-adaptive pcm decoder
// no dependencies; imported by every module of the decoder
`timescale 1ns / 1ps

package brr_pkg;

   // field widths
   localparam int VOICE_W     = 3;
   localparam int HEADER_W    = 8;
   localparam int PAYLOAD_W   = 64;
   localparam int POS_W       = 4;
   localparam int SAMPLE_W    = 15;
   localparam int HIST_W      = 16;
   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 24;

   // defaults and sizes
   localparam int NUM_VOICES_DEF = 8;
   localparam int QUEUE_DEPTH    = 2;

   // arithmetic constants
   localparam int SHIFT_MAX = 12;
   localparam int SAT_MAX   = 32767;
   localparam int SAT_MIN   = -32768;
   localparam int BIG_NEG   = -4096;
   localparam logic [POS_W-1:0] LAST_POS = 4'hf;

   // prediction filter codes
   localparam logic [1:0] FILT_NONE = 2'd0;
   localparam logic [1:0] FILT_ONE  = 2'd1;
   localparam logic [1:0] FILT_TWO  = 2'd2;
   localparam logic [1:0] FILT_THREE = 2'd3;

   // one classified block on its way from front to back
   typedef struct packed {
      logic [VOICE_W-1:0]   voice;
      logic [3:0]           shift;
      logic [1:0]           filt;
      logic                 loop_mark;
      logic                 end_mark;
      logic                 hist_ok;
      logic [PAYLOAD_W-1:0] payload;
   } brr_blk_type;

endpackage

// ----- sv/brr_block_decoder_top.sv -----
// top level of the block-adaptive pcm decoder: front, queue and back end
// depends on brr_pkg, brr_front, brr_queue, brr_back
`timescale 1ns / 1ps

// Each request beat carries one nine-byte compressed block (voice, header byte,
// eight data bytes) and produces sixteen response beats, one decoded sample each,
// the sixteenth with tlast set. The back end makes one sample per clock while the
// consumer takes them; that rate is set by the prediction filter, where each
// sample depends on the one decoded just before it. The next block is taken in the
// same cycle as the previous block's last sample, also for the same voice, since the
// fresh history is forwarded. The front stage and a two-entry queue keep taking
// blocks while the back end works, and the response register lets the back end run
// one sample ahead of a stalled consumer. Voice history resets to zero and needs no
// clearing pass; a voice number at or above NUM_VOICES decodes with zero history
// and leaves all history untouched.

module brr_block_decoder_top #(
   parameter int NUM_VOICES = brr_pkg::NUM_VOICES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: voice[2:0], header[10:3], payload[74:11], zero fill to 80 bits
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [brr_pkg::REQ_TDATA_W-1:0] req_tdata,
   // rsp_tdata: voice_out[2:0], position[6:3], sample[21:7], end_mark[22], loop_mark[23]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [brr_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);
   import brr_pkg::*;

   brr_blk_type front_data, queue_data;
   logic        front_valid, front_ready;
   logic        queue_valid, queue_ready;

   // accept and classify
   brr_front #(
      .NUM_VOICES (NUM_VOICES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .blk_valid  (front_valid),
      .blk_ready  (front_ready),
      .blk_data   (front_data)
   );

   // decouple front from back
   brr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_data  (queue_data)
   );

   // decode samples
   brr_back #(
      .NUM_VOICES (NUM_VOICES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .blk_valid  (queue_valid),
      .blk_ready  (queue_ready),
      .blk_data   (queue_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- sv/brr_front.sv -----
// front stage: accepts compressed blocks and classifies the header
// depends on brr_pkg
`timescale 1ns / 1ps

module brr_front #(
   parameter int NUM_VOICES = brr_pkg::NUM_VOICES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [brr_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                            blk_valid,
   input  logic                            blk_ready,
   output brr_pkg::brr_blk_type            blk_data
);
   import brr_pkg::*;

   logic        full_ff, full_in;
   brr_blk_type blk_ff, blk_in;
   logic [VOICE_W-1:0]   voice;
   logic [HEADER_W-1:0]  header;
   logic [PAYLOAD_W-1:0] payload;

   // unpack the beat
   assign voice   = req_tdata[VOICE_W-1:0];
   assign header  = req_tdata[VOICE_W +: HEADER_W];
   assign payload = req_tdata[VOICE_W+HEADER_W +: PAYLOAD_W];

   // header split and voice range check
   always_comb begin
      blk_in.voice     = voice;
      blk_in.shift     = header[7:4];
      blk_in.filt      = header[3:2];
      blk_in.loop_mark = header[1];
      blk_in.end_mark  = header[0];
      blk_in.hist_ok   = (32'(voice) < NUM_VOICES);
      blk_in.payload   = payload;
   end

   assign req_tready = !full_ff || blk_ready;
   assign blk_valid  = full_ff;
   assign blk_data   = blk_ff;

   // stage occupancy
   always_comb begin
      full_in = full_ff;
      if (req_tvalid && req_tready) begin
         full_in = 1'b1;
      end else if (blk_ready) begin
         full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         blk_ff <= blk_in;
      end
   end

endmodule

// ----- sv/brr_queue.sv -----
// short block queue between the front and the decode back end
// depends on brr_pkg
`timescale 1ns / 1ps

module brr_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  brr_pkg::brr_blk_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output brr_pkg::brr_blk_type out_data
);
   import brr_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   brr_blk_type      entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ----- sv/brr_back.sv -----
// decode back end: one sample per cycle unless the output stalls, per-voice history, output register
// depends on brr_pkg
`timescale 1ns / 1ps

module brr_back #(
   parameter int NUM_VOICES = brr_pkg::NUM_VOICES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            blk_valid,
   output logic                            blk_ready,
   input  brr_pkg::brr_blk_type            blk_data,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [brr_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);
   import brr_pkg::*;

   localparam int VIDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int ACC_W  = 20;

   // block in progress
   logic              busy_ff, busy_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   brr_blk_type       cur_ff, cur_in;
   logic signed [HIST_W-1:0] p1_ff, p1_in, p2_ff, p2_in;

   // per-voice history
   logic signed [HIST_W-1:0] hist_prev_ff  [NUM_VOICES];
   logic signed [HIST_W-1:0] hist_prev2_ff [NUM_VOICES];

   // output register
   logic                 rsp_valid_ff;
   logic [VOICE_W-1:0]   rsp_voice_ff;
   logic [POS_W-1:0]     rsp_pos_ff;
   logic [SAMPLE_W-1:0]  rsp_sample_ff;
   logic                 rsp_end_ff, rsp_loop_ff, rsp_last_ff;

   logic advance, finishing, load, bypass;
   logic [VIDX_W-1:0] cur_idx, head_idx;
   logic [3:0]        voice_cur_ext, voice_head_ext;
   logic signed [3:0]        nib;
   logic signed [16:0]       scaled_full;
   logic signed [ACC_W-1:0]  scaled, pred, acc, p1e, p2e;
   logic signed [HIST_W-1:0] sat;
   logic signed [HIST_W-1:0] new_s;
   logic signed [HIST_W-1:0] head_p1, head_p2;

   assign advance   = busy_ff && (!rsp_valid_ff || rsp_tready);
   assign finishing = advance && (pos_ff == LAST_POS);
   assign blk_ready = !busy_ff || finishing;
   assign load      = blk_valid && blk_ready;

   assign voice_cur_ext  = {1'b0, cur_ff.voice};
   assign voice_head_ext = {1'b0, blk_data.voice};
   assign cur_idx  = voice_cur_ext[VIDX_W-1:0];
   assign head_idx = voice_head_ext[VIDX_W-1:0];

   // nibble pick, high nibble of the first byte first
   function automatic logic [3:0] blk_nib(input logic [PAYLOAD_W-1:0] data,
                                          input logic [POS_W-1:0] pos);
      logic [5:0] base;
      base = {~pos, 2'b00};
      return data[base +: 4];
   endfunction

   assign nib = signed'(blk_nib(cur_ff.payload, pos_ff));

   // scale by the header shift; a shift above SHIFT_MAX gives BIG_NEG for a negative nibble, else zero
   always_comb begin
      scaled_full = 17'(nib) <<< cur_ff.shift;
      if (32'(cur_ff.shift) <= SHIFT_MAX) begin
         scaled = ACC_W'(scaled_full >>> 1);
      end else if (nib < 0) begin
         scaled = ACC_W'(BIG_NEG);
      end else begin
         scaled = '0;
      end
   end

   // prediction from the two previous samples
   always_comb begin
      p1e = ACC_W'(p1_ff);
      p2e = ACC_W'(p2_ff);
      case (cur_ff.filt)
         FILT_NONE: begin
            pred = '0;
         end
         FILT_ONE: begin
            pred = p1e + ((-p1e) >>> 4);
         end
         FILT_TWO: begin
            pred = ACC_W'((p1e <<< 1) + ((-(p1e * 3)) >>> 5) - p2e + (p2e >>> 4));
         end
         FILT_THREE: begin
            pred = ACC_W'((p1e <<< 1) + ((-(p1e * 13)) >>> 6) - p2e + ((p2e * 3) >>> 4));
         end
         default: begin
            pred = '0;
         end
      endcase
      acc = scaled + pred;
   end

   // clamp to 16 bits, then wrap to 15
   always_comb begin
      if (acc < ACC_W'(SAT_MIN)) begin
         sat = HIST_W'(SAT_MIN);
      end else if (acc > ACC_W'(SAT_MAX)) begin
         sat = HIST_W'(SAT_MAX);
      end else begin
         sat = acc[HIST_W-1:0];
      end
      new_s = signed'({sat[SAMPLE_W-1], sat[SAMPLE_W-1:0]});
   end

   // history for the next block, forwarded when the same voice just finished
   assign bypass = finishing && cur_ff.hist_ok && (cur_ff.voice == blk_data.voice);

   always_comb begin
      if (bypass) begin
         head_p1 = new_s;
         head_p2 = p1_ff;
      end else if (blk_data.hist_ok) begin
         head_p1 = hist_prev_ff[head_idx];
         head_p2 = hist_prev2_ff[head_idx];
      end else begin
         head_p1 = '0;
         head_p2 = '0;
      end
   end

   // sequencing of the current block
   always_comb begin
      busy_in = busy_ff;
      pos_in  = pos_ff;
      cur_in  = cur_ff;
      p1_in   = p1_ff;
      p2_in   = p2_ff;
      if (load) begin
         busy_in = 1'b1;
         pos_in  = '0;
         cur_in  = blk_data;
         p1_in   = head_p1;
         p2_in   = head_p2;
      end else if (advance) begin
         busy_in = !finishing;
         pos_in  = pos_ff + 1'b1;
         p1_in   = new_s;
         p2_in   = p1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      p1_ff  <= p1_in;
      p2_ff  <= p2_in;
   end

   // history write at the end of a block
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int v = 0; v < NUM_VOICES; v++) begin
            hist_prev_ff[v]  <= '0;
            hist_prev2_ff[v] <= '0;
         end
      end else if (finishing && cur_ff.hist_ok) begin
         hist_prev_ff[cur_idx]  <= new_s;
         hist_prev2_ff[cur_idx] <= p1_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_voice_ff  <= cur_ff.voice;
         rsp_pos_ff    <= pos_ff;
         rsp_sample_ff <= sat[SAMPLE_W-1:0];
         rsp_end_ff    <= cur_ff.end_mark;
         rsp_loop_ff   <= cur_ff.loop_mark;
         rsp_last_ff   <= (pos_ff == LAST_POS);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {rsp_loop_ff, rsp_end_ff, rsp_sample_ff, rsp_pos_ff, rsp_voice_ff};

   // a new block is taken only when idle or on the final sample
   a_load_only_at_boundary : assert property (@(posedge clock) disable iff (reset)
      load |-> (!busy_ff || pos_ff == LAST_POS))
      else $error("block taken mid-block");

   // the final sample of a block goes out marked last
   a_last_follows_final : assert property (@(posedge clock) disable iff (reset)
      finishing |=> (rsp_valid_ff && rsp_last_ff))
      else $error("final sample not marked last");

   // an idle back end sits at position zero
   a_idle_pos_zero : assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (pos_ff == '0))
      else $error("idle with nonzero position");

   // a mid-block step keeps the block running
   a_mid_block_busy : assert property (@(posedge clock) disable iff (reset)
      (advance && pos_ff != LAST_POS) |=> (busy_ff && pos_ff == $past(pos_ff) + 1'b1))
      else $error("block stopped before its last sample");

endmodule
